// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define QRL_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define QRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/qrl_pkg.sv
// Package for the quadratic refine unit: widths, reset values, register indexes.
package qrl_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int COEFF_WIDTH     = 16;
  localparam int COEFF_FRAC      = 12;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int PIPE_DEPTH      = 3;

  localparam logic [COEFF_WIDTH-1:0] MONO_COEFF_RESET = COEFF_WIDTH'(8192);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_MONO_COEFF = 1'b0,
    CFG_OPP_SIGN   = 1'b1
  } cfg_reg_t;

endpackage

// File: rtl/qrl_in_if.sv
// Input channel: one coarse stencil per beat.
interface qrl_in_if #(
  parameter int VALUE_WIDTH = qrl_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] left_value;
  logic signed [VALUE_WIDTH-1:0] center_value;
  logic signed [VALUE_WIDTH-1:0] right_value;
  logic                          monotonic;

  modport source (output valid, left_value, center_value, right_value, monotonic,
                  input ready);
  modport sink (input valid, left_value, center_value, right_value, monotonic,
                output ready);
endinterface

// File: rtl/qrl_out_if.sv
// Output channel: one pair of fine values per beat.
interface qrl_out_if #(
  parameter int VALUE_WIDTH = qrl_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] fine_low;
  logic signed [VALUE_WIDTH-1:0] fine_high;

  modport source (output valid, fine_low, fine_high, input ready);
  modport sink (input valid, fine_low, fine_high, output ready);
endinterface

// File: rtl/qrl_cfg_if.sv
// Configuration write channel: register index and write data.
interface qrl_cfg_if;
  import qrl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [COEFF_WIDTH-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/quadratic_refine_limited_unit.sv
// Quadratic refine with slope limiter. Takes one beat per cycle when the output
// side keeps up; an accepted beat passes the input, product and result
// registers in turn before its result is valid. Three register stages (input,
// products, result) each advance whenever the next stage is free or moving, so
// a waiting result does not block new beats until all three stages are full.
// The stage after the input register holds the two limiter multiplies (step
// magnitude times coefficient); it sets the clock period. Config writes are
// always ready and take effect at once.
module quadratic_refine_limited_unit #(
  parameter int VALUE_WIDTH = qrl_pkg::VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  qrl_in_if.sink    samples,
  qrl_out_if.source results,
  qrl_cfg_if.sink   cfg
);
  import qrl_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int SW = W + 7;
  localparam int QW = W + 2;
  localparam int DW = W + 1;
  localparam int MW = DW + COEFF_WIDTH;
  localparam int RW = W + 6;

  localparam logic [MW:0] ROUND_HALF = (MW + 1)'(1) << (COEFF_FRAC + 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'({1'b0, {(W - 1){1'b1}}});
  localparam logic signed [RW-1:0] SAT_LO =
    RW'(signed'({1'b1, {(W - 1){1'b0}}}));

  // config registers
  logic [COEFF_WIDTH-1:0] mono_coeff;
  logic                   opp_sign_zeroth;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mono_coeff      <= MONO_COEFF_RESET;
      opp_sign_zeroth <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_MONO_COEFF: mono_coeff <= cfg.data;
        CFG_OPP_SIGN:   opp_sign_zeroth <= cfg.data[0];
      endcase
    end
  end

  // pipeline handshake
  logic v0, v1, v2;
  logic ready0, ready1, ready2;

  assign ready2        = !v2 || results.ready;
  assign ready1        = !v1 || ready2;
  assign ready0        = !v0 || ready1;
  assign samples.ready = ready0;

  // stage 0: input register
  logic signed [W-1:0] l0, c0, r0;
  logic                mono0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ready0) begin
      v0 <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready0 && samples.valid) begin
      l0    <= samples.left_value;
      c0    <= samples.center_value;
      r0    <= samples.right_value;
      mono0 <= samples.monotonic;
    end
  end

  // stage 0 logic: quadratic sums, steps, products
  logic signed [SW-1:0] lx, cx, rx, sum_lo, sum_hi;
  logic signed [QW-1:0] q_lo, q_hi;
  logic signed [DW-1:0] ls, rs, drl;
  logic [DW-1:0]        ls_mag, rs_mag, drl_mag;
  logic [MW-1:0]        m_diff, m_l, m_r;
  logic                 same0, opp0;
  logic signed [W-1:0]  vmax0, vmin0;

  always_comb begin
    lx     = SW'(l0);
    cx     = SW'(c0);
    rx     = SW'(r0);
    sum_lo = lx * SW'(5) + cx * SW'(30) - rx * SW'(3) + SW'(16);
    sum_hi = rx * SW'(5) + cx * SW'(30) - lx * SW'(3) + SW'(16);
    q_lo   = QW'(sum_lo >>> 5);
    q_hi   = QW'(sum_hi >>> 5);

    ls      = DW'(c0) - DW'(l0);
    rs      = DW'(r0) - DW'(c0);
    drl     = DW'(r0) - DW'(l0);
    ls_mag  = ls[DW-1]  ? -ls  : ls;
    rs_mag  = rs[DW-1]  ? -rs  : rs;
    drl_mag = drl[DW-1] ? -drl : drl;

    m_diff = MW'(drl_mag) << (COEFF_FRAC - 1);
    m_l    = ls_mag * mono_coeff;
    m_r    = rs_mag * mono_coeff;

    same0 = (!ls[DW-1] && (|ls) && !rs[DW-1] && (|rs)) || (ls[DW-1] && rs[DW-1]);
    vmax0 = (l0 > r0) ? l0 : r0;
    vmin0 = (l0 > r0) ? r0 : l0;
    opp0  = opp_sign_zeroth &&
            ((l0[W-1] && !r0[W-1] && (|r0)) || (r0[W-1] && !l0[W-1] && (|l0)));
  end

  // stage 1: product register
  logic signed [W-1:0]  c1, vmax1, vmin1;
  logic signed [QW-1:0] qlo1, qhi1;
  logic [MW-1:0]        m_diff1, m_l1, m_r1;
  logic                 same1, lsneg1, mono1, opp1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && v0) begin
      c1      <= c0;
      vmax1   <= vmax0;
      vmin1   <= vmin0;
      qlo1    <= q_lo;
      qhi1    <= q_hi;
      m_diff1 <= m_diff;
      m_l1    <= m_l;
      m_r1    <= m_r;
      same1   <= same0;
      lsneg1  <= ls[DW-1];
      mono1   <= mono0;
      opp1    <= opp0;
    end
  end

  // stage 1 logic: limiter, selection, saturation
  logic                 out_of_range;
  logic [MW-1:0]        m_a, m_min;
  logic [MW:0]          s_full;
  logic signed [RW-1:0] slope, cx1, lim_lo, lim_hi, sel_lo, sel_hi;
  logic [W-1:0]         sat_lo, sat_hi;

  always_comb begin
    out_of_range = (qlo1 > QW'(vmax1)) || (qhi1 > QW'(vmax1)) ||
                   (qlo1 < QW'(vmin1)) || (qhi1 < QW'(vmin1));
    m_a    = (m_l1 < m_diff1) ? m_l1 : m_diff1;
    m_min  = (m_r1 < m_a) ? m_r1 : m_a;
    s_full = {1'b0, m_min} + ROUND_HALF;
    slope  = signed'(RW'(s_full >> (COEFF_FRAC + 2)));
    cx1    = RW'(c1);
    lim_lo = lsneg1 ? cx1 + slope : cx1 - slope;
    lim_hi = lsneg1 ? cx1 - slope : cx1 + slope;

    sel_lo = RW'(qlo1);
    sel_hi = RW'(qhi1);
    if (mono1) begin
      if (!same1) begin
        sel_lo = cx1;
        sel_hi = cx1;
      end else if (out_of_range) begin
        sel_lo = lim_lo;
        sel_hi = lim_hi;
      end
    end
    if (opp1) begin
      sel_lo = cx1;
      sel_hi = cx1;
    end

    if (sel_lo > SAT_HI) begin
      sat_lo = SAT_HI[W-1:0];
    end else if (sel_lo < SAT_LO) begin
      sat_lo = SAT_LO[W-1:0];
    end else begin
      sat_lo = sel_lo[W-1:0];
    end
    if (sel_hi > SAT_HI) begin
      sat_hi = SAT_HI[W-1:0];
    end else if (sel_hi < SAT_LO) begin
      sat_hi = SAT_LO[W-1:0];
    end else begin
      sat_hi = sel_hi[W-1:0];
    end
  end

  // stage 2: result register
  logic [W-1:0] f_lo2, f_hi2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      f_lo2 <= sat_lo;
      f_hi2 <= sat_hi;
    end
  end

  assign results.valid     = v2;
  assign results.fine_low  = signed'(f_lo2);
  assign results.fine_high = signed'(f_hi2);

endmodule

// File: rtl/qrl_checker.sv
// Port-level checker for the quadratic refine unit, with its bind.
`include "assert_macros.svh"

module qrl_checker #(
  parameter int VALUE_WIDTH = qrl_pkg::VALUE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] fine_low,
  input logic [VALUE_WIDTH-1:0] fine_high,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);
  import qrl_pkg::*;

  // beats in flight inside the unit
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  `QRL_ASSERT(a_no_phantom, out_valid, pending != 3'd0, "result beat with no input beat")
  `QRL_ASSERT(a_depth, 1'b1, pending <= 3'(PIPE_DEPTH), "more beats in flight than stages")
  `QRL_ASSERT(a_ready_empty, pending == 3'd0, in_ready, "empty unit refuses input")
  `QRL_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(fine_low) && $stable(fine_high), "stalled result changed")
  `QRL_ASSERT(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind quadratic_refine_limited_unit qrl_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_qrl_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (samples.valid),
  .in_ready (samples.ready),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .fine_low (results.fine_low),
  .fine_high(results.fine_high),
  .cfg_valid(cfg.valid),
  .cfg_ready(cfg.ready)
);

// File: bench/refine_checker.sv
// Checker for the quadratic refine unit: predicts each fine pair and compares it.
`timescale 1ns / 100ps
module refine_checker #(
  parameter int VALUE_WIDTH = qrl_pkg::VALUE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  qrl_in_if    samples,
  qrl_out_if   results,
  qrl_cfg_if   cfg,
  output int   error_count,
  output int   pending,
  output int   checked
);
  import qrl_pkg::*;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] fine_low;
    logic signed [VALUE_WIDTH-1:0] fine_high;
  } fine_pair_t;

  fine_pair_t             fine_pairs_due[$];
  logic [COEFF_WIDTH-1:0] coeff_k;
  logic                   opp_zero;

  function automatic logic signed [VALUE_WIDTH-1:0] clamp_value(longint x);
    longint top_v;
    longint bot_v;
    top_v = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
    bot_v = -top_v - 1;
    if (x > top_v) return VALUE_WIDTH'(top_v);
    if (x < bot_v) return VALUE_WIDTH'(bot_v);
    return VALUE_WIDTH'(x);
  endfunction

  function automatic longint unsigned magnitude(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic fine_pair_t refine_cell(logic signed [VALUE_WIDTH-1:0] l, c, r,
                                             logic mono);
    longint          lv, cv, rv, lo, hi, ls, rs;
    longint unsigned m, ml, mr, slope;
    fine_pair_t      res;
    lv = longint'(l);
    cv = longint'(c);
    rv = longint'(r);
    // divide by 32, round half up
    lo = (5 * lv + 30 * cv - 3 * rv + 16) >>> 5;
    hi = (-3 * lv + 30 * cv + 5 * rv + 16) >>> 5;
    if (mono) begin
      ls = cv - lv;
      rs = rv - cv;
      if (!((ls > 0 && rs > 0) || (ls < 0 && rs < 0))) begin
        lo = cv;
        hi = cv;
      end else if ((lo > lv && lo > rv) || (hi > lv && hi > rv) ||
                   (lo < lv && lo < rv) || (hi < lv && hi < rv)) begin
        // limit product at scale 2^-12; slope is a quarter of it, rounded half away from zero
        m  = magnitude(rv - lv) << (COEFF_FRAC - 1);
        ml = magnitude(ls) * coeff_k;
        mr = magnitude(rs) * coeff_k;
        if (ml < m) m = ml;
        if (mr < m) m = mr;
        slope = (m + (64'd1 << (COEFF_FRAC + 1))) >> (COEFF_FRAC + 2);
        if (ls < 0) begin
          lo = cv + longint'(slope);
          hi = cv - longint'(slope);
        end else begin
          lo = cv - longint'(slope);
          hi = cv + longint'(slope);
        end
      end
    end
    if (opp_zero && ((lv < 0 && rv > 0) || (lv > 0 && rv < 0))) begin
      lo = cv;
      hi = cv;
    end
    res.fine_low  = clamp_value(lo);
    res.fine_high = clamp_value(hi);
    return res;
  endfunction

  always @(posedge clk) begin
    fine_pair_t want;
    if (rst) begin
      coeff_k  = MONO_COEFF_RESET;
      opp_zero = 1'b0;
      fine_pairs_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_MONO_COEFF) coeff_k = cfg.data;
        else if (cfg.index == CFG_OPP_SIGN) opp_zero = cfg.data[0];
      end
      if (samples.valid && samples.ready)
        fine_pairs_due.push_back(refine_cell(samples.left_value, samples.center_value,
                                             samples.right_value, samples.monotonic));
      if (results.valid && results.ready) begin
        if (fine_pairs_due.size() == 0) begin
          $error("fine pair beat with no stencil outstanding: low %0d high %0d",
                 results.fine_low, results.fine_high);
          error_count++;
        end else begin
          want = fine_pairs_due.pop_front();
          checked++;
          if (results.fine_low !== want.fine_low) begin
            $error("fine_low: expected %0d, got %0d", want.fine_low, results.fine_low);
            error_count++;
          end
          if (results.fine_high !== want.fine_high) begin
            $error("fine_high: expected %0d, got %0d", want.fine_high, results.fine_high);
            error_count++;
          end
        end
      end
    end
    pending = fine_pairs_due.size();
  end

endmodule

// File: bench/testbench.sv
// Top of the refine unit bench: clock, reset, stencil and register stimulus, verdict.
`timescale 1ns / 100ps
module testbench;
  import qrl_pkg::*;

  localparam int VW          = VALUE_WIDTH_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int PER_SETTING = 85;
  localparam logic signed [VW-1:0] MAX_VAL = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] MIN_VAL = {1'b1, {(VW-1){1'b0}}};

  logic clk;
  logic rst;
  logic no_idle;
  int   err_count;
  int   pending;
  int   checked;
  int   idle_cycles;
  int   n_settings;

  qrl_in_if  #(.VALUE_WIDTH(VW)) samples_ch ();
  qrl_out_if #(.VALUE_WIDTH(VW)) results_ch ();
  qrl_cfg_if                     cfg_ch ();

  quadratic_refine_limited_unit #(.VALUE_WIDTH(VW)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  refine_checker #(.VALUE_WIDTH(VW)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples_ch),
    .results     (results_ch),
    .cfg         (cfg_ch),
    .error_count (err_count),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (samples_ch.valid && samples_ch.ready) ||
        (results_ch.valid && results_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: random stall before each beat
  initial begin
    int stall;
    results_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        results_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      results_ch.ready = 1'b1;
      do @(posedge clk); while (!results_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_cell(input logic signed [VW-1:0] l, c, r, input logic mono);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      samples_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_ch.left_value   = l;
    samples_ch.center_value = c;
    samples_ch.right_value  = r;
    samples_ch.monotonic    = mono;
    samples_ch.valid        = 1'b1;
    do @(posedge clk); while (!samples_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    samples_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [COEFF_WIDTH-1:0] val);
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic signed [VW-1:0] scaled_random();
    return $signed(VW'($urandom)) >>> $urandom_range(0, VW - 1);
  endfunction

  function automatic logic signed [VW-1:0] near_limit();
    case ($urandom_range(0, 2))
      0:       return MAX_VAL - VW'($urandom_range(0, 1023));
      1:       return MIN_VAL + VW'($urandom_range(0, 1023));
      default: return scaled_random();
    endcase
  endfunction

  task automatic run_directed();
    send_cell(0, 0, 0, 1'b0);
    send_cell(MAX_VAL, MAX_VAL, MAX_VAL, 1'b0);
    send_cell(MIN_VAL, MIN_VAL, MIN_VAL, 1'b1);
    send_cell(MIN_VAL, 0, MAX_VAL, 1'b1);
    send_cell(MAX_VAL, 0, MIN_VAL, 1'b1);
    send_cell(MAX_VAL, MAX_VAL, MIN_VAL, 1'b0);
    send_cell(MIN_VAL, MIN_VAL, MAX_VAL, 1'b0);
    send_cell(32'sh10000, 32'sh10000, 32'sh30000, 1'b1);
    send_cell(0, 32'sh10000, 0, 1'b1);
    send_cell(0, 32'sh10000, 32'sh100000, 1'b1);
    send_cell(0, 32'sh10000, 32'sh100000, 1'b0);
    send_cell(32'sh100000, 32'sh10000, 0, 1'b1);
    send_cell(0, 32'sh10000, 32'sh20000, 1'b1);
    send_cell(2, 0, -2, 1'b0);
    send_cell(-2, 0, 2, 1'b0);
    send_cell(-32'sh10000, 32'sh5000, 32'sh10000, 1'b0);
    send_cell(32'sh10000, 0, -32'sh10000, 1'b0);
    send_cell(0, 32'sh10000, -32'sh10000, 1'b0);
    send_cell(-1, -1, 1, 1'b1);
    send_cell(MAX_VAL, MIN_VAL, MAX_VAL, 1'b1);
    send_cell(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 1'b1);
    send_cell(32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 1'b0);
  endtask

  task automatic random_cell();
    logic signed [VW-1:0] c, dl, dr, l, r;
    int mode;
    mode = $urandom_range(0, 9);
    c    = scaled_random();
    if (mode < 5) begin
      // steady ramp around the centre, occasionally flat on one side
      dl = VW'($urandom) >> $urandom_range(1, VW - 1);
      dr = VW'($urandom) >> $urandom_range(1, VW - 1);
      case ($urandom_range(0, 7))
        0:       dl = 0;
        1:       dr = 0;
        default: ;
      endcase
      if ($urandom_range(0, 1)) begin
        l = c - dl;
        r = c + dr;
      end else begin
        l = c + dl;
        r = c - dr;
      end
      send_cell(l, c, r, $urandom_range(0, 7) != 0);
    end else if (mode < 7) begin
      send_cell(VW'($urandom), VW'($urandom), VW'($urandom), 1'($urandom_range(0, 1)));
    end else if (mode == 7) begin
      send_cell(VW'($urandom_range(0, 64)) - VW'(32), VW'($urandom_range(0, 64)) - VW'(32),
                VW'($urandom_range(0, 64)) - VW'(32), 1'($urandom_range(0, 1)));
    end else if (mode == 8) begin
      send_cell(near_limit(), near_limit(), near_limit(), 1'($urandom_range(0, 1)));
    end else begin
      send_cell(scaled_random(), c, scaled_random(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [COEFF_WIDTH-1:0] coeff_set[6];
    logic                   opp_set[6];
    rst                     = 1'b1;
    no_idle                 = 1'b0;
    n_settings              = 1;
    samples_ch.valid        = 1'b0;
    samples_ch.left_value   = '0;
    samples_ch.center_value = '0;
    samples_ch.right_value  = '0;
    samples_ch.monotonic    = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = CFG_MONO_COEFF;
    cfg_ch.data             = '0;
    coeff_set = '{MONO_COEFF_RESET, 16'd0, 16'd65535, 16'd1, 16'd4096,
                  COEFF_WIDTH'($urandom)};
    opp_set   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom_range(0, 1))};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        wait_drained();
        write_reg(CFG_MONO_COEFF, coeff_set[p]);
        // upper data bits are don't-care for the one-bit register
        write_reg(CFG_OPP_SIGN, {(COEFF_WIDTH - 1)'($urandom), opp_set[p]});
        n_settings++;
      end
      if (p == 0 || p == 3) run_directed();
      for (int i = 0; i < PER_SETTING; i++) begin
        if (i % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (i == PER_SETTING / 2 && p == 1) wait_drained();
        random_cell();
      end
    end
    wait_drained();

    $display("Checked %0d fine pairs over %0d limiter settings", checked, n_settings);
    $display("(coefficient 0, 1, 4096, 2.0, max and random; opposite-sign forcing on and off)");
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
